/* hdl/grc_pkg.sv */
// Package for the region crossover unit: field widths, opcodes, status codes,
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package grc_pkg;

    localparam int MAX_LENGTH_DEF = 2048;
    localparam int MIN_LENGTH_DEF = 8;
    localparam int WORD_BITS_DEF  = 8;

    localparam int OP_W    = 3;
    localparam int INSTR_W = 8;
    localparam int MERIT_W = 48;
    localparam int RAND_W  = 16;
    localparam int RIDX_W  = 11;
    localparam int LEN_W   = 12;
    localparam int MC_W    = 7;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_LOADA = 3'd1;
    localparam logic [OP_W-1:0] OP_LOADB = 3'd2;
    localparam logic [OP_W-1:0] OP_RUN   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_RDATA   = 2'd2;
    localparam logic [1:0] ST_RRANGE  = 2'd3;

    // Copy segment selects for the run sequencer
    typedef enum logic [2:0] {
        SEG_A_HEAD = 3'd0,
        SEG_B_MID  = 3'd1,
        SEG_A_TAIL = 3'd2,
        SEG_B_HEAD = 3'd3,
        SEG_A_MID  = 3'd4,
        SEG_B_TAIL = 3'd5
    } t_seg;

    typedef struct packed {
        logic       clear;
        logic       load_a;
        logic       load_b;
        logic       setup;      // register cut fractions and operands
        logic       mul_step;   // one multiply/divide step
        logic       decide;     // compute new lengths and exchange
        logic       seg_start;  // open a copy segment
        t_seg       seg;
        logic       copy;       // one copy word
        logic       finish;     // write lengths, form run result
        logic       read_req;   // issue a read
        logic       read_emit;  // form read result
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic seg_done;
    } t_stat;

endpackage
`default_nettype wire

/* hdl/grc_ctrl.sv */
// Controller for the region crossover unit: one-hot sequencer over the
// arithmetic steps and the six copy segments. Depends on grc_pkg.
`default_nettype none
module grc_ctrl
    import grc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_ready,
    input  wire logic            i_out_free,
    output logic                 o_out_load,
    output t_cmd                 o_cmd,
    input  wire t_stat           i_stat
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SEGST  = 7'b0001000,
        S_COPY   = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_READ   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_seg   r_seg, n_seg;
    logic   w_acc;

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign w_acc   = i_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_seg = r_seg;
        o_cmd = '0;
        o_cmd.seg = r_seg;
        o_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_op)
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        OP_LOADA: o_cmd.load_a = 1'b1;
                        OP_LOADB: o_cmd.load_b = 1'b1;
                        OP_RUN: begin
                            o_cmd.setup = 1'b1;
                            n_state = S_MUL;
                        end
                        OP_READ: begin
                            o_cmd.read_req = 1'b1;
                            n_state = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_seg = SEG_A_HEAD;
                n_state = S_SEGST;
            end
            S_SEGST: begin
                o_cmd.seg_start = 1'b1;
                n_state = S_COPY;
            end
            S_COPY: begin
                if (i_stat.seg_done) begin
                    if (r_seg == SEG_B_TAIL) begin
                        n_state = S_FIN;
                    end else begin
                        n_seg = t_seg'(r_seg + 3'd1);
                        n_state = S_SEGST;
                    end
                end else begin
                    o_cmd.copy = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                o_out_load = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                o_cmd.read_emit = 1'b1;
                o_out_load = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seg <= SEG_A_HEAD;
        end else begin
            r_state <= n_state;
            r_seg <= n_seg;
        end
    end

endmodule
`default_nettype wire

/* hdl/grc_datapath.sv */
// Datapath for the region crossover unit: parent and child memories, lengths,
// shift-add multiplier with restoring divider for cuts and merits, copy engine.
// Depends on grc_pkg.
`default_nettype none
module grc_datapath
    import grc_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int MIN_LENGTH = MIN_LENGTH_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic [MC_W-1:0]    i_module_count,
    input  wire logic [INSTR_W-1:0] i_instruction,
    input  wire logic [MERIT_W-1:0] i_merit_a,
    input  wire logic [MERIT_W-1:0] i_merit_b,
    input  wire logic [RAND_W-1:0]  i_rand_start,
    input  wire logic [RAND_W-1:0]  i_rand_end,
    input  wire logic               i_child_select,
    input  wire logic [RIDX_W-1:0]  i_read_index,
    output logic [1:0]              o_status,
    output logic [INSTR_W-1:0]      o_word,
    output logic [LEN_W-1:0]        o_len0,
    output logic [LEN_W-1:0]        o_len1,
    output logic [MERIT_W-1:0]      o_merit0,
    output logic [MERIT_W-1:0]      o_merit1,
    output logic                    o_exchanged
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = AW + 1;
    // Generic divisor is up to 65536, so 17 bits
    localparam int DW = 17;
    localparam int PW = MERIT_W + DW + 1;   // product width for merits
    localparam int NJOB = 6;                // s*la, e*la, s*lb, e*lb, m0, m1
    localparam int JW = 3;
    localparam int CW = $clog2(PW + 1);

    // Memories
    logic [WORD_BITS-1:0] r_pa [MAX_LENGTH];
    logic [WORD_BITS-1:0] r_pb [MAX_LENGTH];
    logic [WORD_BITS-1:0] r_ca [MAX_LENGTH];
    logic [WORD_BITS-1:0] r_cb [MAX_LENGTH];

    logic [LW-1:0] r_la, r_lb, r_cl0, r_cl1;
    logic [WORD_BITS-1:0] w_wr;
    assign w_wr = WORD_BITS'(i_instruction);

    // Parent loads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && (r_la < LW'(MAX_LENGTH))) r_pa[r_la[AW-1:0]] <= w_wr;
        if (i_cmd.load_b && (r_lb < LW'(MAX_LENGTH))) r_pb[r_lb[AW-1:0]] <= w_wr;
    end

    // Run operands
    logic [DW-1:0] r_d, r_sn, r_en, r_c, r_st;
    logic [MERIT_W-1:0] r_ma, r_mb;
    logic [DW-1:0] w_sn, w_en, w_d;
    logic [RAND_W+MC_W-1:0] w_qs, w_qe;
    assign w_qs = RAND_W'(i_rand_start) * MC_W'(i_module_count);
    assign w_qe = RAND_W'(i_rand_end) * MC_W'(i_module_count);
    always_comb begin
        if (i_module_count == '0) begin
            w_d = DW'(32'd65536);
            w_sn = DW'(i_rand_start);
            w_en = DW'(i_rand_end);
        end else begin
            w_d = DW'(i_module_count);
            w_sn = DW'(w_qs[RAND_W+MC_W-1:RAND_W]);
            w_en = DW'(w_qe[RAND_W+MC_W-1:RAND_W]);
        end
    end

    // Sequential multiply then divide: one bit per cycle
    logic [JW-1:0] r_job;
    logic          r_phase;     // 0 multiply, 1 divide
    logic [CW-1:0] r_bit;
    logic [PW-1:0] r_acc, r_mcand, r_quo, r_rem;
    logic [PW-1:0] r_hold;      // first product of merit pair
    logic [DW-1:0] r_mplier;
    logic [PW-1:0] r_res [NJOB];

    logic [PW-1:0] w_job_a;
    logic [DW-1:0] w_job_b;
    always_comb begin
        case (r_job)
            3'd0: begin w_job_a = PW'(r_sn); w_job_b = DW'(r_la); end
            3'd1: begin w_job_a = PW'(r_en); w_job_b = DW'(r_la); end
            3'd2: begin w_job_a = PW'(r_sn); w_job_b = DW'(r_lb); end
            3'd3: begin w_job_a = PW'(r_en); w_job_b = DW'(r_lb); end
            3'd4: begin w_job_a = PW'(r_ma); w_job_b = r_st; end
            3'd5: begin w_job_a = PW'(r_mb); w_job_b = r_st; end
            default: begin w_job_a = '0; w_job_b = '0; end
        endcase
    end
    // Cross term for merit jobs: merit_b*c for job 4, merit_a*c for job 5
    logic [PW-1:0] w_cross_a;
    assign w_cross_a = (r_job == 3'd4) ? PW'(r_mb) : PW'(r_ma);
    logic r_cross;  // second multiply of a merit job pending

    // Partial product of the current multiplier bit
    logic [PW-1:0] w_term;
    assign w_term = r_mplier[DW-1] ? (r_mcand << r_bit) : '0;

    logic [PW-1:0] w_rem_sh;
    assign w_rem_sh = {r_rem[PW-2:0], r_acc[PW-1]};

    assign o_stat.mul_done = r_phase && (r_bit == '0) && (r_job == JW'(NJOB - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_d <= w_d;
            r_sn <= (w_sn > w_en) ? w_en : w_sn;
            r_en <= (w_sn > w_en) ? w_sn : w_en;
            r_c <= (w_sn > w_en) ? (w_sn - w_en) : (w_en - w_sn);
            r_st <= w_d - ((w_sn > w_en) ? (w_sn - w_en) : (w_en - w_sn));
            r_ma <= i_merit_a;
            r_mb <= i_merit_b;
            r_job <= '0;
            r_phase <= 1'b0;
            r_cross <= 1'b0;
            r_bit <= CW'(DW);
            r_acc <= '0;
            r_mcand <= '0;
            r_mplier <= '0;
            r_quo <= '0;
            r_rem <= '0;
        end else if (i_cmd.mul_step) begin
            if (!r_phase) begin
                if (r_bit == CW'(DW)) begin
                    // load operands of this multiply
                    r_mcand <= r_cross ? w_cross_a : w_job_a;
                    r_mplier <= r_cross ? r_c : w_job_b;
                    r_acc <= '0;
                    r_bit <= CW'(DW - 1);
                end else begin
                    r_mplier <= r_mplier << 1;
                    if (r_bit == '0) begin
                        if (r_job >= 3'd4 && !r_cross) begin
                            r_cross <= 1'b1;
                            r_hold <= r_acc + w_term;
                            r_bit <= CW'(DW);
                        end else begin
                            r_acc <= (r_cross ? r_hold : '0) + r_acc + w_term;
                            r_phase <= 1'b1;
                            r_bit <= CW'(PW);
                            r_rem <= '0;
                            r_quo <= '0;
                        end
                    end else begin
                        r_acc <= r_acc + w_term;
                        r_bit <= r_bit - 1'b1;
                    end
                end
            end else begin
                if (r_bit == '0) begin
                    r_res[r_job] <= r_quo;
                    r_job <= r_job + 1'b1;
                    r_phase <= 1'b0;
                    r_cross <= 1'b0;
                    r_bit <= CW'(DW);
                end else begin
                    // restoring division step
                    if (w_rem_sh >= PW'(r_d)) begin
                        r_rem <= w_rem_sh - PW'(r_d);
                        r_quo <= {r_quo[PW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_quo <= {r_quo[PW-2:0], 1'b0};
                    end
                    r_acc <= r_acc << 1;
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    // Decision: new lengths, legality, exchange
    logic [LW-1:0] r_s0, r_e0, r_s1, r_e1;
    logic          r_ok, r_ex;
    logic [LW+1:0] w_n0, w_n1;
    assign w_n0 = (LW+2)'(r_la) - (LW+2)'(r_res[1][LW-1:0]) + (LW+2)'(r_res[0][LW-1:0])
                + (LW+2)'(r_res[3][LW-1:0]) - (LW+2)'(r_res[2][LW-1:0]);
    assign w_n1 = (LW+2)'(r_lb) - (LW+2)'(r_res[3][LW-1:0]) + (LW+2)'(r_res[2][LW-1:0])
                + (LW+2)'(r_res[1][LW-1:0]) - (LW+2)'(r_res[0][LW-1:0]);
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_s0 <= r_res[0][LW-1:0];
            r_e0 <= r_res[1][LW-1:0];
            r_s1 <= r_res[2][LW-1:0];
            r_e1 <= r_res[3][LW-1:0];
            r_ok <= (w_n0 >= (LW+2)'(MIN_LENGTH)) && (w_n0 <= (LW+2)'(MAX_LENGTH))
                 && (w_n1 >= (LW+2)'(MIN_LENGTH)) && (w_n1 <= (LW+2)'(MAX_LENGTH));
            r_ex <= ({r_c, 1'b0}) > {1'b0, r_d};
        end
    end

    // Copy engine: source pointer, end bound, destination pointer per child
    logic [LW-1:0] r_src, r_end, r_at0, r_at1;
    logic          r_from_b, r_to1;
    logic [LW-1:0] w_from, w_to;
    logic          w_fb, w_t1;
    always_comb begin
        w_fb = 1'b0; w_t1 = 1'b0; w_from = '0; w_to = '0;
        case (i_cmd.seg)
            SEG_A_HEAD: begin w_from = '0;   w_to = r_ok ? r_s0 : r_la; end
            SEG_B_MID:  begin w_fb = 1'b1; w_from = r_s1; w_to = r_ok ? r_e1 : r_s1; end
            SEG_A_TAIL: begin w_from = r_e0; w_to = r_ok ? r_la : r_e0; end
            SEG_B_HEAD: begin w_fb = 1'b1; w_t1 = 1'b1; w_from = '0;
                              w_to = r_ok ? r_s1 : r_lb; end
            SEG_A_MID:  begin w_t1 = 1'b1; w_from = r_s0; w_to = r_ok ? r_e0 : r_s0; end
            SEG_B_TAIL: begin w_fb = 1'b1; w_t1 = 1'b1; w_from = r_e1;
                              w_to = r_ok ? r_lb : r_e1; end
            default: ;
        endcase
    end

    logic [LW-1:0] w_at;
    assign w_at = r_to1 ? r_at1 : r_at0;
    assign o_stat.seg_done = (r_src >= r_end) || (r_src >= LW'(MAX_LENGTH))
                          || (w_at >= LW'(MAX_LENGTH));

    // child 0 lands in store B when exchanged
    logic w_to_b;
    assign w_to_b = r_to1 ^ r_ex;

    // Copy pipeline: registered parent word, written into its child store in the next cycle
    logic [WORD_BITS-1:0] r_cw;
    logic                 r_cw_v, r_cw_b;
    logic [AW-1:0]        r_cw_at;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_at0 <= '0;
            r_at1 <= '0;
        end
        if (i_cmd.seg_start) begin
            r_src <= w_from;
            r_end <= w_to;
            r_from_b <= w_fb;
            r_to1 <= w_t1;
        end
        if (i_cmd.copy) begin
            if (r_from_b) r_cw <= r_pb[r_src[AW-1:0]];
            else          r_cw <= r_pa[r_src[AW-1:0]];
            r_cw_b <= w_to_b;
            r_cw_at <= w_at[AW-1:0];
            r_src <= r_src + 1'b1;
            if (r_to1) r_at1 <= r_at1 + 1'b1;
            else       r_at0 <= r_at0 + 1'b1;
        end
    end

    // Mark a fetched word pending for the child write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cw_v <= 1'b0;
        else          r_cw_v <= i_cmd.copy;
    end

    // Write the fetched word into its child store
    always_ff @(posedge i_clk) begin
        if (r_cw_v) begin
            if (r_cw_b) r_cb[r_cw_at] <= r_cw;
            else        r_ca[r_cw_at] <= r_cw;
        end
    end

    // Lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_la <= '0;
            r_lb <= '0;
            r_cl0 <= '0;
            r_cl1 <= '0;
        end else begin
            if (i_cmd.load_a && (r_la < LW'(MAX_LENGTH))) r_la <= r_la + 1'b1;
            if (i_cmd.load_b && (r_lb < LW'(MAX_LENGTH))) r_lb <= r_lb + 1'b1;
            if (i_cmd.finish) begin
                r_cl0 <= r_ex ? r_at1 : r_at0;
                r_cl1 <= r_ex ? r_at0 : r_at1;
            end
        end
    end

    // Read path: registered memory read
    logic [WORD_BITS-1:0] r_rd;
    logic                 r_rin;
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_req) begin
            r_rd <= i_child_select ? r_cb[AW'(i_read_index)] : r_ca[AW'(i_read_index)];
            r_rin <= (LW'(i_read_index) < (i_child_select ? r_cl1 : r_cl0))
                  && (32'(i_read_index) < MAX_LENGTH);
        end
    end

    // Result formation
    always_comb begin
        o_len0 = LEN_W'(r_cl0);
        o_len1 = LEN_W'(r_cl1);
        o_status = ST_RRANGE;
        o_word = '0;
        o_merit0 = '0;
        o_merit1 = '0;
        o_exchanged = 1'b0;
        if (i_cmd.finish) begin
            o_status = r_ok ? ST_DONE : ST_REFUSED;
            o_len0 = LEN_W'(r_ex ? r_at1 : r_at0);
            o_len1 = LEN_W'(r_ex ? r_at0 : r_at1);
            o_merit0 = r_ex ? r_res[5][MERIT_W-1:0] : r_res[4][MERIT_W-1:0];
            o_merit1 = r_ex ? r_res[4][MERIT_W-1:0] : r_res[5][MERIT_W-1:0];
            o_exchanged = r_ex;
        end else if (r_rin) begin
            o_status = ST_RDATA;
            o_word = INSTR_W'(r_rd);
        end
    end

endmodule
`default_nettype wire

/* hdl/genome_region_crossover_unit.sv */
// Region crossover unit, top level: stream ports, config register, output
// register. A run does its arithmetic (4 cut jobs, 2 merit jobs) in the
// bit-serial multiply/divide unit, then the copy engine copies the words.
// One item at a time. Synchronous active-low reset clears lengths, module_count
// and control.
`default_nettype none
module genome_region_crossover_unit
    import grc_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int MIN_LENGTH = MIN_LENGTH_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_data,     // module_count[6:0]
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[2:0], instruction[10:3], merit_a[58:11], merit_b[106:59],
    // rand_start[122:107], rand_end[138:123], read_index[149:139]
    input  wire logic [151:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // child_select
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], word_out[9:2], child0_length[21:10], child1_length[33:22],
    // child0_merit[81:34], child1_merit[129:82], children_exchanged[130]
    output logic [135:0]      m_axis_tdata
);

    logic [MC_W-1:0] r_mc;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_out_load;
    logic [1:0] w_status;
    logic [INSTR_W-1:0] w_word;
    logic [LEN_W-1:0] w_l0, w_l1;
    logic [MERIT_W-1:0] w_m0, w_m1;
    logic w_ex;
    logic r_ovalid;
    logic [130:0] r_odata;

    assign o_cfg_ready = 1'b1;
    // Hold the config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mc <= '0;
        else if (i_cfg_valid) r_mc <= i_cfg_data[MC_W-1:0];
    end

    grc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_op(s_axis_tdata[2:0]),
        .o_ready(s_axis_tready), .i_out_free(!r_ovalid),
        .o_out_load(w_out_load), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    grc_datapath #(
        .MAX_LENGTH(MAX_LENGTH), .MIN_LENGTH(MIN_LENGTH), .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_module_count(r_mc),
        .i_instruction(s_axis_tdata[10:3]),
        .i_merit_a(s_axis_tdata[58:11]), .i_merit_b(s_axis_tdata[106:59]),
        .i_rand_start(s_axis_tdata[122:107]), .i_rand_end(s_axis_tdata[138:123]),
        .i_child_select(s_axis_tuser), .i_read_index(s_axis_tdata[149:139]),
        .o_status(w_status), .o_word(w_word), .o_len0(w_l0), .o_len1(w_l1),
        .o_merit0(w_m0), .o_merit1(w_m1), .o_exchanged(w_ex)
    );

    // Output register: hold result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_out_load) r_odata <= {w_ex, w_m1, w_m0, w_l1, w_l0, w_word, w_status};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_odata};

endmodule
`default_nettype wire

/* verif/genome_region_crossover_unit_test.sv */
// Self-checking testbench for genome_region_crossover_unit: drives parent loads, runs and
// reads over the stream ports and checks each result against a built-in crossover predictor.
// Depends on grc_pkg and the unit's RTL only.
`default_nettype none
module genome_region_crossover_unit_test;
    import grc_pkg::*;

    localparam int MAXLEN = 2048;
    localparam int MINLEN = 8;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [INSTR_W-1:0] instr;
        logic [MERIT_W-1:0] merit_a;
        logic [MERIT_W-1:0] merit_b;
        logic [RAND_W-1:0]  rand_start;
        logic [RAND_W-1:0]  rand_end;
        logic               child_sel;
        logic [RIDX_W-1:0]  read_idx;
    } genome_item_t;

    typedef struct {
        logic [1:0]         status;
        logic [7:0]         word;
        logic [LEN_W-1:0]   len0;
        logic [LEN_W-1:0]   len1;
        logic [MERIT_W-1:0] merit0;
        logic [MERIT_W-1:0] merit1;
        logic               exchanged;
    } crossover_result_t;

    // Directed row: an item repeated reps times (loads step the word), optional typed status
    typedef struct {
        genome_item_t it;
        int           reps;
        bit           typed;
        logic [1:0]   typed_status;
    } directed_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [7:0]   i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic [151:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tready = 1'b0;
    wire          o_cfg_ready;
    wire          s_axis_tready;
    wire          m_axis_tvalid;
    wire [135:0]  m_axis_tdata;

    genome_region_crossover_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Predictor state
    logic [7:0]        par_a [MAXLEN];
    logic [7:0]        par_b [MAXLEN];
    logic [7:0]        kid_a [MAXLEN];
    logic [7:0]        kid_b [MAXLEN];
    int                par_a_len = 0;
    int                par_b_len = 0;
    int                kid_len [2] = '{0, 0};
    logic [MC_W-1:0]   module_cnt = '0;

    crossover_result_t pending_results [$];
    int                errors = 0;
    int                items_sent = 0;
    bit                no_gaps = 1'b0;
    bit                rx_free = 1'b0;
    int                rx_stall_req = 0;
    int                rx_stall_left = 0;

    // Advance predictor state by one item; return 1 with the result when one is due
    function automatic bit crossover_predict(input genome_item_t it,
                                             output crossover_result_t r);
        logic [63:0] d, sn, en, c, st, s0, e0, s1, e1, n0, n1, la, lb, ma, mb, m0, m1, t;
        logic [7:0]  w0 [$];
        logic [7:0]  w1 [$];
        bit          ok, ex;
        r = '{default: '0};
        case (it.op)
            OP_CLEAR: begin
                par_a_len = 0;
                par_b_len = 0;
                kid_len[0] = 0;
                kid_len[1] = 0;
                return 1'b0;
            end
            OP_LOADA: begin
                if (par_a_len < MAXLEN) begin
                    par_a[par_a_len] = it.instr;
                    par_a_len++;
                end
                return 1'b0;
            end
            OP_LOADB: begin
                if (par_b_len < MAXLEN) begin
                    par_b[par_b_len] = it.instr;
                    par_b_len++;
                end
                return 1'b0;
            end
            OP_RUN: begin
                la = par_a_len;
                lb = par_b_len;
                ma = it.merit_a;
                mb = it.merit_b;
                if (module_cnt == 0) begin
                    d = 65536;
                    sn = it.rand_start;
                    en = it.rand_end;
                end else begin
                    d = module_cnt;
                    sn = (64'(it.rand_start) * d) >> 16;
                    en = (64'(it.rand_end) * d) >> 16;
                end
                if (sn > en) begin
                    t = sn;
                    sn = en;
                    en = t;
                end
                c = en - sn;
                st = d - c;
                s0 = sn * la / d;
                e0 = en * la / d;
                s1 = sn * lb / d;
                e1 = en * lb / d;
                n0 = la - (e0 - s0) + (e1 - s1);
                n1 = lb - (e1 - s1) + (e0 - s0);
                ok = n0 >= MINLEN && n0 <= MAXLEN && n1 >= MINLEN && n1 <= MAXLEN;
                ex = 2 * c > d;
                // Build both child sequences, head, exchanged middle, tail
                if (ok) begin
                    for (int i = 0; i < s0; i++) w0.push_back(par_a[i]);
                    for (int i = s1; i < e1; i++) w0.push_back(par_b[i]);
                    for (int i = e0; i < la; i++) w0.push_back(par_a[i]);
                    for (int i = 0; i < s1; i++) w1.push_back(par_b[i]);
                    for (int i = s0; i < e0; i++) w1.push_back(par_a[i]);
                    for (int i = e1; i < lb; i++) w1.push_back(par_b[i]);
                end else begin
                    for (int i = 0; i < la; i++) w0.push_back(par_a[i]);
                    for (int i = 0; i < lb; i++) w1.push_back(par_b[i]);
                end
                for (int i = 0; i < w0.size() && i < MAXLEN; i++) begin
                    if (ex) kid_b[i] = w0[i];
                    else kid_a[i] = w0[i];
                end
                for (int i = 0; i < w1.size() && i < MAXLEN; i++) begin
                    if (ex) kid_a[i] = w1[i];
                    else kid_b[i] = w1[i];
                end
                kid_len[ex ? 1 : 0] = (w0.size() > MAXLEN) ? MAXLEN : w0.size();
                kid_len[ex ? 0 : 1] = (w1.size() > MAXLEN) ? MAXLEN : w1.size();
                m0 = (ma * st + mb * c) / d;
                m1 = (mb * st + ma * c) / d;
                r.status = ok ? ST_DONE : ST_REFUSED;
                r.merit0 = ex ? m1[47:0] : m0[47:0];
                r.merit1 = ex ? m0[47:0] : m1[47:0];
                r.exchanged = ex;
                r.len0 = kid_len[0];
                r.len1 = kid_len[1];
                return 1'b1;
            end
            OP_READ: begin
                if (it.read_idx < kid_len[it.child_sel]) begin
                    r.status = ST_RDATA;
                    r.word = it.child_sel ? kid_b[it.read_idx] : kid_a[it.read_idx];
                end else begin
                    r.status = ST_RRANGE;
                end
                r.len0 = kid_len[0];
                r.len1 = kid_len[1];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Offer one item, hold it until the transaction, then record its expected result
    task automatic send_item(input genome_item_t it, input bit typed, input logic [1:0] tst);
        int                gap;
        crossover_result_t r;
        bit                due;
        gap = pick_gap();
        repeat (gap) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata = {2'b0, it.read_idx, it.rand_end, it.rand_start, it.merit_b,
                        it.merit_a, it.instr, it.op};
        s_axis_tuser = it.child_sel;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        due = crossover_predict(it, r);
        if (typed) pending_results.push_back('{status: tst, default: '0});
        else if (due) pending_results.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Write module_count once the unit has gone quiet
    task automatic write_module_count(input logic [7:0] v);
        wait_drained();
        repeat (16) @(negedge i_clk);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        module_cnt = v[MC_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic genome_item_t blank_item(input logic [OP_W-1:0] op);
        genome_item_t it;
        it = '{default: '0};
        it.op = op;
        return it;
    endfunction

    function automatic logic [MERIT_W-1:0] rand_merit();
        case ($urandom_range(0, 3))
            0: return '1;
            1: return MERIT_W'($urandom_range(0, 65535));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [RAND_W-1:0] rand_frac();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic genome_item_t run_item();
        genome_item_t it;
        it = blank_item(OP_RUN);
        it.merit_a = rand_merit();
        it.merit_b = rand_merit();
        it.rand_start = rand_frac();
        it.rand_end = rand_frac();
        it.instr = $urandom;
        return it;
    endfunction

    function automatic genome_item_t read_item();
        genome_item_t it;
        int           sel;
        sel = $urandom_range(0, 1);
        it = blank_item(OP_READ);
        it.child_sel = sel;
        it.read_idx = $urandom_range(0, kid_len[sel] + 2);
        return it;
    endfunction

    function automatic genome_item_t noise_item();
        genome_item_t it;
        it.op = $urandom_range(0, 7);
        it.instr = $urandom;
        it.merit_a = {$urandom, $urandom};
        it.merit_b = {$urandom, $urandom};
        it.rand_start = $urandom;
        it.rand_end = $urandom;
        it.child_sel = $urandom;
        it.read_idx = $urandom;
        return it;
    endfunction

    // Clear and load both parents, then runs, each followed by reads of the children
    task automatic crossover_sequence();
        genome_item_t it;
        int           na, nb, nruns;
        na = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(6, 16);
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(6, 16);
        send_item(blank_item(OP_CLEAR), 1'b0, ST_DONE);
        repeat (na) begin
            it = blank_item(OP_LOADA);
            it.instr = $urandom;
            send_item(it, 1'b0, ST_DONE);
        end
        repeat (nb) begin
            it = blank_item(OP_LOADB);
            it.instr = $urandom;
            send_item(it, 1'b0, ST_DONE);
        end
        nruns = $urandom_range(1, 3);
        repeat (nruns) begin
            send_item(run_item(), 1'b0, ST_DONE);
            repeat ($urandom_range(1, 4)) send_item(read_item(), 1'b0, ST_DONE);
        end
    endtask

    // Receiver: random hold-offs, plus a long requested stall
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left--;
        end else if (rx_stall_req > 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left = rx_stall_req - 1;
            rx_stall_req = 0;
        end else if (rx_free) begin
            m_axis_tready = 1'b1;
        end else if ($urandom_range(0, 59) == 0) begin
            m_axis_tready = 1'b0;
            rx_stall_left = $urandom_range(10, 40);
        end else begin
            m_axis_tready = ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        crossover_result_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.word = m_axis_tdata[9:2];
            got.len0 = m_axis_tdata[21:10];
            got.len1 = m_axis_tdata[33:22];
            got.merit0 = m_axis_tdata[81:34];
            got.merit1 = m_axis_tdata[129:82];
            got.exchanged = m_axis_tdata[130];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %h got %h", $time, want.status, got.status);
                end
                if (got.word !== want.word) begin
                    errors++;
                    $display("%0t: word_out expected %h got %h", $time, want.word, got.word);
                end
                if (got.len0 !== want.len0) begin
                    errors++;
                    $display("%0t: child0_length expected %0d got %0d", $time, want.len0,
                             got.len0);
                end
                if (got.len1 !== want.len1) begin
                    errors++;
                    $display("%0t: child1_length expected %0d got %0d", $time, want.len1,
                             got.len1);
                end
                if (got.merit0 !== want.merit0) begin
                    errors++;
                    $display("%0t: child0_merit expected %h got %h", $time, want.merit0,
                             got.merit0);
                end
                if (got.merit1 !== want.merit1) begin
                    errors++;
                    $display("%0t: child1_merit expected %h got %h", $time, want.merit1,
                             got.merit1);
                end
                if (got.exchanged !== want.exchanged) begin
                    errors++;
                    $display("%0t: children_exchanged expected %b got %b", $time,
                             want.exchanged, got.exchanged);
                end
            end
        end
    end

    // Hard stop in case the unit hangs
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        directed_row_t dir_tab [21];
        genome_item_t  it;
        logic [7:0]    mc_plan [8];
        dir_tab[0]  = '{blank_item(OP_READ), 1, 1'b1, ST_RRANGE};
        dir_tab[1]  = '{blank_item(OP_READ), 1, 1'b1, ST_RRANGE};
        dir_tab[1].it.child_sel = 1'b1;
        dir_tab[1].it.read_idx = '1;
        dir_tab[2]  = '{blank_item(OP_RUN), 1, 1'b1, ST_REFUSED};
        dir_tab[3]  = '{blank_item(3'd5), 1, 1'b0, ST_DONE};
        dir_tab[4]  = '{blank_item(3'd6), 1, 1'b0, ST_DONE};
        dir_tab[5]  = '{blank_item(3'd7), 1, 1'b0, ST_DONE};
        dir_tab[6]  = '{blank_item(OP_LOADA), 10, 1'b0, ST_DONE};
        dir_tab[6].it.instr = 8'hF8;
        dir_tab[7]  = '{blank_item(OP_LOADB), 12, 1'b0, ST_DONE};
        dir_tab[7].it.instr = 8'h7A;
        dir_tab[8]  = '{blank_item(OP_RUN), 1, 1'b0, ST_DONE};
        dir_tab[8].it.merit_a = '1;
        dir_tab[8].it.rand_end = '1;
        dir_tab[9]  = '{blank_item(OP_READ), 1, 1'b0, ST_DONE};
        dir_tab[10] = '{blank_item(OP_READ), 1, 1'b0, ST_DONE};
        dir_tab[10].it.child_sel = 1'b1;
        dir_tab[10].it.read_idx = 11;
        dir_tab[11] = '{blank_item(OP_READ), 1, 1'b0, ST_DONE};
        dir_tab[11].it.read_idx = '1;
        dir_tab[12] = '{blank_item(OP_RUN), 1, 1'b0, ST_DONE};
        dir_tab[12].it.merit_a = '1;
        dir_tab[12].it.merit_b = '1;
        dir_tab[12].it.rand_start = '1;
        dir_tab[13] = '{blank_item(OP_RUN), 1, 1'b0, ST_DONE};
        dir_tab[13].it.rand_start = 16'h4000;
        dir_tab[13].it.rand_end = 16'h4000;
        dir_tab[13].it.merit_b = 48'h1_0000;
        dir_tab[14] = '{blank_item(OP_RUN), 1, 1'b0, ST_DONE};
        dir_tab[14].it.rand_start = 16'h8000;
        dir_tab[14].it.rand_end = 16'h0001;
        dir_tab[14].it.merit_a = 48'h3_8000;
        dir_tab[15] = '{blank_item(OP_READ), 1, 1'b0, ST_DONE};
        dir_tab[15].it.child_sel = 1'b1;
        dir_tab[16] = '{blank_item(OP_CLEAR), 1, 1'b0, ST_DONE};
        dir_tab[17] = '{blank_item(OP_READ), 1, 1'b1, ST_RRANGE};
        dir_tab[18] = '{blank_item(OP_LOADA), 3, 1'b0, ST_DONE};
        dir_tab[19] = '{blank_item(OP_RUN), 1, 1'b0, ST_DONE};
        dir_tab[19].it.rand_end = 16'h9000;
        dir_tab[20] = '{blank_item(OP_READ), 1, 1'b0, ST_DONE};
        dir_tab[20].it.read_idx = 2;
        mc_plan = '{8'd0, 8'd1, 8'd64, 8'd127, 8'($urandom_range(2, 63)),
                    8'($urandom_range(2, 63)), 8'd5, 8'd0};

        // Hold reset, then start on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (dir_tab[r]) begin
            it = dir_tab[r].it;
            for (int k = 0; k < dir_tab[r].reps; k++) begin
                send_item(it, dir_tab[r].typed, dir_tab[r].typed_status);
                it.instr = it.instr + 8'd1;
            end
        end

        // Random phases, one module_count setting each
        foreach (mc_plan[p]) begin
            write_module_count(mc_plan[p]);
            no_gaps = (p == 1);
            rx_free = (p == 1);
            if (p == 2) begin
                // Long receiver stall while reads keep coming
                rx_stall_req = 400;
                repeat (8) send_item(read_item(), 1'b0, ST_DONE);
            end
            while (items_sent < 40 + (p + 1) * 30) begin
                if ($urandom_range(0, 9) < 8) crossover_sequence();
                else send_item(noise_item(), 1'b0, ST_DONE);
            end
        end

        wait_drained();
        rx_free = 1'b1;
        repeat (200) @(negedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
